FILE: rtl/core/mplnrm_pkg.sv
// ----------------------------------------------------------------------------
// mplnrm_pkg
// Shared constants, payload words and unit request types for the mean-pool
// and L2-normalize core.
// ----------------------------------------------------------------------------
`default_nettype none

package mplnrm_pkg;

    localparam int MAX_DIMS   = 512;
    localparam int MAX_TOKENS = 512;

    localparam int POS_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int EFF_W  = $clog2(MAX_DIMS + 1);
    localparam int CNT_W  = $clog2(MAX_TOKENS + 1);
    localparam int DIMS_W = 10;
    localparam int SUM_W  = 32;
    localparam int MEAN_W = 16;
    localparam int INV_W  = 32;
    localparam int DIV_W  = 64;
    // Squared norm: each squared mean is at most 2^30.
    localparam int SQ_W   = 31 + $clog2(MAX_DIMS);
    localparam int PROD_W = MEAN_W + INV_W;

    typedef enum logic [1:0] {
        ACT_ACCUM  = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic signed [15:0] hidden_value;
        logic [8:0]         read_index;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] normalized_value;
        logic               empty_flag;
    } out_word_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [SQ_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/mplnrm_divider.sv
// ----------------------------------------------------------------------------
// mplnrm_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mplnrm_divider (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  mplnrm_pkg::div_req_t  req,
    output mplnrm_pkg::div_rsp_t  rsp
);

    localparam int STEP_W = $clog2(mplnrm_pkg::DIV_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [mplnrm_pkg::DIV_W-1:0]  quo_reg;
    logic [mplnrm_pkg::SQ_W-1:0]   rem_reg;
    logic [mplnrm_pkg::SQ_W-1:0]   dvs_reg;

    logic [mplnrm_pkg::SQ_W:0]     shifted;
    logic                          fits;

    assign shifted = {rem_reg, quo_reg[mplnrm_pkg::DIV_W-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(mplnrm_pkg::DIV_W);
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg <= mplnrm_pkg::SQ_W'(shifted - {1'b0, dvs_reg});
                end else begin
                    rem_reg <= shifted[mplnrm_pkg::SQ_W-1:0];
                end
                quo_reg  <= {quo_reg[mplnrm_pkg::DIV_W-2:0], fits};
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/core/mplnrm_isqrt.sv
// ----------------------------------------------------------------------------
// mplnrm_isqrt
// Integer square root of a 64-bit word, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mplnrm_isqrt (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           start,
    input  wire [mplnrm_pkg::DIV_W-1:0]   value,
    output logic                          done,
    output logic [mplnrm_pkg::INV_W-1:0]  root
);

    localparam int W      = mplnrm_pkg::DIV_W;
    localparam int STEPS  = W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [W-1:0]      v_reg;
    logic [W-1:0]      res_reg;
    logic [W-1:0]      bit_reg;

    logic [W-1:0]      trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(STEPS);
                v_reg    <= value;
                res_reg  <= '0;
                bit_reg  <= W'(1) << (W - 2);
            end else if (busy_reg) begin
                if (v_reg >= trial) begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The root of a 64-bit word always fits in 32 bits.
    assign done = done_reg;
    assign root = res_reg[mplnrm_pkg::INV_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/mean_pool_l2_normalize_core.sv
// ----------------------------------------------------------------------------
// mean_pool_l2_normalize_core
// Per-dimension token accumulation, mean pooling and L2 normalization.
// ----------------------------------------------------------------------------
// Input words on s_* carry an action: accumulate one element, finish, read
// one normalized element, or clear. Finish and read each return one word on
// m_*; accumulate and clear return none. dims_in_use is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle.
// The block handles one word at a time; s_ready is high only when idle.
// The block does not enforce idle-only writes of dims_in_use. Accumulate is
// a read-modify-write of the sum memory. A read runs the 64-step mean
// divider. Finish runs the mean divider once per dimension in use, then the
// norm division and the 32-step square root; a finish with no tokens skips
// all of them. After reset, and after a clear word, a clearing pass zeroes
// all 512 entries of the sum memory, during which s_ready stays low.
// A result waits in the output register while m_ready is low. The block still
// takes its next word meanwhile; a second result then holds inside the block
// until the first has been handed over.
// ----------------------------------------------------------------------------
`default_nettype none

module mean_pool_l2_normalize_core (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire [mplnrm_pkg::DIMS_W-1:0]       cfg_wdata,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  mplnrm_pkg::in_word_t               s_data,
    output logic                               m_valid,
    input  wire                                m_ready,
    output mplnrm_pkg::out_word_t              m_data
);

    localparam int POS_W = mplnrm_pkg::POS_W;
    localparam int EFF_W = mplnrm_pkg::EFF_W;
    localparam int CNT_W = mplnrm_pkg::CNT_W;
    localparam int SUM_W = mplnrm_pkg::SUM_W;
    localparam int SQ_W  = mplnrm_pkg::SQ_W;
    localparam int DIV_W = mplnrm_pkg::DIV_W;
    localparam int INV_W = mplnrm_pkg::INV_W;
    localparam int MW    = mplnrm_pkg::MEAN_W;
    localparam int PW    = mplnrm_pkg::PROD_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ACC_WR, S_DIV_START, S_DIV_WAIT, S_FIN_SQ,
        S_NORM_DIV, S_NORM_WAIT, S_SQRT_WAIT, S_RD_MUL, S_RD_RND, S_OUT
    } state_t;

    state_t                    state_reg;
    logic [mplnrm_pkg::DIMS_W-1:0] dims_reg;
    logic [POS_W-1:0]          pos_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [INV_W-1:0]          inv_reg;
    logic                      finished_reg;
    logic [POS_W-1:0]          clr_addr_reg;
    logic [POS_W-1:0]          acc_addr_reg;
    logic signed [15:0]        hv_reg;
    logic [POS_W-1:0]          fin_idx_reg;
    logic                      mode_read_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [MW-1:0]             mean_mag_reg;
    logic                      mean_neg_reg;
    logic                      src_neg_reg;
    logic [PW-1:0]             prod_reg;
    mplnrm_pkg::out_word_t     res_reg;
    mplnrm_pkg::out_word_t     m_data_reg;
    logic                      m_valid_reg;

    logic [SUM_W-1:0]          mem [mplnrm_pkg::MAX_DIMS];
    logic [SUM_W-1:0]          rdata_reg;

    logic                      mem_re;
    logic [POS_W-1:0]          mem_ra;
    logic                      mem_we;
    logic [POS_W-1:0]          mem_wa;
    logic [SUM_W-1:0]          mem_wd;

    logic [EFF_W-1:0]          eff_dims;
    logic [POS_W-1:0]          pos_use;
    logic [EFF_W-1:0]          pos_inc;
    logic                      accept;
    logic                      idx_ok;
    logic                      fin_last;
    logic [SUM_W:0]            sum_wide;
    logic [SUM_W-1:0]          sum_sat;
    logic [SUM_W-1:0]          src_mag;
    logic [DIV_W-1:0]          q_mean;
    logic [MW-1:0]             mean_clamp;
    logic [31:0]               mean_sq;
    logic [PW-1:0]             prod_rnd;
    logic [PW-18:0]            q_norm;
    logic [MW-1:0]             q_clamp;
    logic                      sqrt_done;
    logic [INV_W-1:0]          sqrt_root;

    mplnrm_pkg::div_req_t      div_req;
    mplnrm_pkg::div_rsp_t      div_rsp;

    // Effective dimension count: dims_in_use held to 1..MAX_DIMS.
    always_comb begin
        if (dims_reg == '0) begin
            eff_dims = EFF_W'(1);
        end else if (32'(dims_reg) > 32'(mplnrm_pkg::MAX_DIMS)) begin
            eff_dims = EFF_W'(mplnrm_pkg::MAX_DIMS);
        end else begin
            eff_dims = EFF_W'(dims_reg);
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign pos_use  = (EFF_W'(pos_reg) >= eff_dims) ? '0 : pos_reg;
    assign pos_inc  = EFF_W'(acc_addr_reg) + 1'b1;
    assign idx_ok   = (32'(s_data.read_index) < 32'(eff_dims));
    assign fin_last = ((EFF_W'(fin_idx_reg) + 1'b1) >= eff_dims);

    assign sum_wide = {rdata_reg[SUM_W-1], rdata_reg}
                    + {{(SUM_W + 1 - 16){hv_reg[15]}}, hv_reg};
    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign src_mag = rdata_reg[SUM_W-1] ? (~rdata_reg + 1'b1) : rdata_reg;

    // Divider requests: a rounded mean per dimension, or the reciprocal of the squared norm.
    always_comb begin
        div_req = '0;
        if (state_reg == S_DIV_START) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(src_mag) + DIV_W'(cnt_reg >> 1);
            div_req.divisor  = SQ_W'(cnt_reg);
        end else if (state_reg == S_NORM_DIV && sq_reg != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = '1;
            div_req.divisor  = sq_reg;
        end
    end

    mplnrm_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    mplnrm_isqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_NORM_WAIT && div_rsp.done),
        .value   (div_rsp.quotient),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign q_mean = div_rsp.quotient;
    always_comb begin
        if (src_neg_reg) begin
            mean_clamp = (q_mean > DIV_W'(32768)) ? MW'(32768) : q_mean[MW-1:0];
        end else begin
            mean_clamp = (q_mean > DIV_W'(32767)) ? MW'(32767) : q_mean[MW-1:0];
        end
    end

    assign mean_sq  = 32'(mean_mag_reg) * 32'(mean_mag_reg);
    assign prod_rnd = prod_reg + PW'(32'h0001_0000);
    assign q_norm   = prod_rnd[PW-1:17];
    always_comb begin
        if (mean_neg_reg) begin
            q_clamp = (q_norm > (PW-17)'(32768)) ? MW'(32768) : q_norm[MW-1:0];
        end else begin
            q_clamp = (q_norm > (PW-17)'(32767)) ? MW'(32767) : q_norm[MW-1:0];
        end
    end

    // Sum memory ports.
    always_comb begin
        mem_re = 1'b0;
        mem_ra = '0;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_addr_reg;
            end
            S_IDLE: begin
                if (accept) begin
                    case (s_data.action)
                        mplnrm_pkg::ACT_ACCUM: begin
                            mem_re = 1'b1;
                            mem_ra = pos_use;
                        end
                        mplnrm_pkg::ACT_FINISH: begin
                            mem_re = (cnt_reg != '0);
                        end
                        mplnrm_pkg::ACT_READ: begin
                            mem_re = idx_ok;
                            mem_ra = POS_W'(s_data.read_index);
                        end
                        default: begin
                            mem_re = 1'b0;
                        end
                    endcase
                end
            end
            S_ACC_WR: begin
                mem_we = 1'b1;
                mem_wa = acc_addr_reg;
                mem_wd = sum_sat;
            end
            S_FIN_SQ: begin
                mem_re = !fin_last;
                mem_ra = fin_idx_reg + 1'b1;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            dims_reg     <= mplnrm_pkg::DIMS_W'(384);
            pos_reg      <= '0;
            cnt_reg      <= '0;
            inv_reg      <= '0;
            finished_reg <= 1'b0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                dims_reg <= cfg_wdata;
            end
            // In S_OUT the output register is reloaded below instead.
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == POS_W'(mplnrm_pkg::MAX_DIMS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        case (s_data.action)
                            mplnrm_pkg::ACT_ACCUM: begin
                                acc_addr_reg <= pos_use;
                                hv_reg       <= s_data.hidden_value;
                                state_reg    <= S_ACC_WR;
                            end
                            mplnrm_pkg::ACT_FINISH: begin
                                finished_reg  <= 1'b1;
                                inv_reg       <= '0;
                                mode_read_reg <= 1'b0;
                                fin_idx_reg   <= '0;
                                sq_reg        <= '0;
                                res_reg       <= '{normalized_value: '0,
                                                   empty_flag: (cnt_reg == '0)};
                                state_reg     <= (cnt_reg == '0) ? S_OUT : S_DIV_START;
                            end
                            mplnrm_pkg::ACT_READ: begin
                                mode_read_reg <= 1'b1;
                                res_reg <= '{normalized_value: '0,
                                             empty_flag: (!finished_reg || cnt_reg == '0)};
                                if (!finished_reg || cnt_reg == '0 || !idx_ok) begin
                                    state_reg <= S_OUT;
                                end else begin
                                    state_reg <= S_DIV_START;
                                end
                            end
                            default: begin
                                pos_reg      <= '0;
                                cnt_reg      <= '0;
                                inv_reg      <= '0;
                                finished_reg <= 1'b0;
                                clr_addr_reg <= '0;
                                state_reg    <= S_CLEAR;
                            end
                        endcase
                    end
                end
                S_ACC_WR: begin
                    finished_reg <= 1'b0;
                    if (pos_inc >= eff_dims) begin
                        pos_reg <= '0;
                        if (32'(cnt_reg) < 32'(mplnrm_pkg::MAX_TOKENS)) begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end else begin
                        pos_reg <= pos_inc[POS_W-1:0];
                    end
                    state_reg <= S_IDLE;
                end
                S_DIV_START: begin
                    src_neg_reg <= rdata_reg[SUM_W-1];
                    state_reg   <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        mean_mag_reg <= mean_clamp;
                        mean_neg_reg <= src_neg_reg;
                        state_reg    <= mode_read_reg ? S_RD_MUL : S_FIN_SQ;
                    end
                end
                S_FIN_SQ: begin
                    sq_reg      <= sq_reg + SQ_W'(mean_sq);
                    fin_idx_reg <= fin_idx_reg + 1'b1;
                    state_reg   <= fin_last ? S_NORM_DIV : S_DIV_START;
                end
                S_NORM_DIV: begin
                    // An all-zero mean leaves the inverse norm at zero.
                    state_reg <= (sq_reg == '0) ? S_OUT : S_NORM_WAIT;
                end
                S_NORM_WAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= S_SQRT_WAIT;
                    end
                end
                S_SQRT_WAIT: begin
                    if (sqrt_done) begin
                        inv_reg   <= sqrt_root;
                        state_reg <= S_OUT;
                    end
                end
                S_RD_MUL: begin
                    prod_reg  <= PW'(mean_mag_reg) * PW'(inv_reg);
                    state_reg <= S_RD_RND;
                end
                S_RD_RND: begin
                    res_reg.normalized_value <= mean_neg_reg ? (~q_clamp + 1'b1) : q_clamp;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/mplnrm_checker.sv
// ----------------------------------------------------------------------------
// mplnrm_checker
// Port-level assertions for the mean-pool and L2-normalize core.
// ----------------------------------------------------------------------------
`default_nettype none

module mplnrm_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_valid,
    input wire                           s_ready,
    input mplnrm_pkg::in_word_t          s_data,
    input wire                           m_valid,
    input wire                           m_ready,
    input mplnrm_pkg::out_word_t         m_data
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Reset starts the clearing pass: no input taken, no result shown.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block not busy clearing after reset");

    // One word at a time: the cycle after an accept is never ready.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in progress");

    // Accumulate produces no result.
    a_accum_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == mplnrm_pkg::ACT_ACCUM && !m_valid
        |=> !m_valid)
        else $error("accumulate produced a result word");

    // An empty result always carries a zero value.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.empty_flag |-> m_data.normalized_value == 16'sd0)
        else $error("empty result with nonzero value");

endmodule

bind mean_pool_l2_normalize_core mplnrm_checker u_mplnrm_checker (.*);

`default_nettype wire
